// File: design/gre_rw_pkg.sv
// Package: shared types, frame-layout and register-file constants for the GRE type rewriter.
package gre_rw_pkg;

    // Frame layout
    localparam logic [7:0] TYPE_POS        = 8'd12;   // first EtherType byte
    localparam logic [7:0] TAG_HI          = 8'h81;   // 802.1Q TPID high byte
    localparam logic [7:0] TAG_LO          = 8'h00;   // 802.1Q TPID low byte
    localparam logic [7:0] UNTAGGED_IPV4   = 8'd14;
    localparam logic [7:0] TAG_BYTES       = 8'd4;
    localparam logic [7:0] PROTO_OFFSET    = 8'd9;
    localparam logic [7:0] PROTO_GRE       = 8'd47;
    localparam logic [3:0] IHL_MASK        = 4'hF;
    localparam logic [3:0] MIN_IHL         = 4'd5;
    localparam logic [7:0] GRE_TYPE_OFFSET = 8'd2;

    // Register file
    localparam logic [15:0] RESET_TYPE     = 16'h6558;
    localparam logic        REG_REPL_TYPE  = 1'b0;    // register index, paddr[2]

    // One result item, handed from the parser to the output register
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       rewritten;
    } gre_rw_result_t;

endpackage

// File: design/gre_protocol_type_rewriter_unit.sv
// Top level: GRE protocol-type rewriter with APB register port and stream channels.
// Result: an accepted input item is registered and appears on m_tdata in the next cycle.
// Throughput: one item per cycle; s_tready stays high while the output register
//   is empty or being drained in the same cycle.
// Reset (aresetn low, synchronous): frame state cleared, output register emptied,
//   replacement type returns to 0x6558.
module gre_protocol_type_rewriter_unit #(
    parameter int MAX_FRAME_BYTES = 16384
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // last_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // out_last
    output logic [0:0]  m_tuser,   // [0] was_rewritten
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gre_rw_pkg::*;

    logic           in_accept;
    logic           cfg_write;
    logic [15:0]    repl_type_reg;
    gre_rw_result_t result;
    gre_rw_result_t out_reg;
    logic           m_valid_reg;

    // --- register port: single register at byte address 0 ---
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_REPL_TYPE);
    assign prdata    = (paddr[2] == REG_REPL_TYPE) ? {16'd0, repl_type_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repl_type_reg <= RESET_TYPE;
        end else if (cfg_write) begin
            repl_type_reg <= pwdata[15:0];
        end
    end

    // --- input side: accept whenever the output slot is free or draining ---
    assign s_tready  = !m_valid_reg || m_tready;
    assign in_accept = s_tvalid && s_tready;

    gre_rw_parse #(
        .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
    ) u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .repl_type (repl_type_reg),
        .result    (result)
    );

    // --- output register ---
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // payload needs no reset; loaded on every accepted item
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            out_reg <= result;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = out_reg.data;
    assign m_tlast    = out_reg.last;
    assign m_tuser[0] = out_reg.rewritten;

    // --- checks ---
    // a rewritten item carries one of the two replacement bytes
    a_rewrite_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && out_reg.rewritten |->
            (out_reg.data == repl_type_reg[15:8]) || (out_reg.data == repl_type_reg[7:0]))
        else $error("rewritten item does not hold a replacement byte");

    // backpressure only while a result is held
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_valid_reg)
        else $error("input stalled with empty output register");

    // an accepted final byte shows up as a final result item next cycle
    a_last_forward: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && s_tlast |=> m_valid_reg && out_reg.last)
        else $error("final item not forwarded");

endmodule

// File: design/gre_rw_parse.sv
// Frame parser: tracks byte position, tag/IHL/protocol, and builds each result item.
module gre_rw_parse #(
    parameter int MAX_FRAME_BYTES = 16384
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_accept,
    input  logic [7:0]                 in_byte,
    input  logic                       in_last,
    input  logic [15:0]                repl_type,
    output gre_rw_pkg::gre_rw_result_t result
);
    import gre_rw_pkg::*;

    localparam int PW = $clog2(MAX_FRAME_BYTES);
    localparam int CW = (PW > 8) ? PW : 8;

    logic [PW-1:0] pos_reg, pos_next;
    logic [7:0]    type_hi_reg, type_hi_next;
    logic          vlan_reg, vlan_next;
    logic [3:0]    ihl_reg, ihl_next;
    logic          gre_reg, gre_next;

    logic [CW-1:0] pos_w, ip_w, proto_w, g_w;
    logic          in_range;
    logic          hit_hi, hit_lo;

    assign pos_w    = CW'(pos_reg);
    assign in_range = (pos_reg != PW'(MAX_FRAME_BYTES - 1));
    assign ip_w     = CW'(UNTAGGED_IPV4) + (vlan_reg ? CW'(TAG_BYTES) : '0);
    assign proto_w  = ip_w + CW'(PROTO_OFFSET);
    assign g_w      = ip_w + CW'({ihl_reg, 2'b00}) + CW'(GRE_TYPE_OFFSET);

    always_comb begin
        hit_hi       = 1'b0;
        hit_lo       = 1'b0;
        type_hi_next = type_hi_reg;
        vlan_next    = vlan_reg;
        ihl_next     = ihl_reg;
        gre_next     = gre_reg;
        pos_next     = pos_reg;
        if (in_range) begin
            if (pos_w == CW'(TYPE_POS)) begin
                type_hi_next = in_byte;
            end else if (pos_w == CW'(TYPE_POS) + CW'(1)) begin
                vlan_next = (type_hi_reg == TAG_HI) && (in_byte == TAG_LO);
            end else if (pos_w == ip_w) begin
                ihl_next = in_byte[3:0] & IHL_MASK;
            end else if (pos_w == proto_w) begin
                gre_next = (in_byte == PROTO_GRE);
            end else if (gre_reg && (ihl_reg >= MIN_IHL)) begin
                // never start a rewrite on the final byte
                hit_hi = (pos_w == g_w) && !in_last;
                hit_lo = (pos_w == g_w + CW'(1));
            end
            pos_next = pos_reg + PW'(1);
        end
        if (in_last) begin
            type_hi_next = '0;
            vlan_next    = 1'b0;
            ihl_next     = '0;
            gre_next     = 1'b0;
            pos_next     = '0;
        end
    end

    always_comb begin
        result.data      = hit_hi ? repl_type[15:8] : (hit_lo ? repl_type[7:0] : in_byte);
        result.last      = in_last;
        result.rewritten = hit_hi || hit_lo;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            type_hi_reg <= '0;
            vlan_reg    <= 1'b0;
            ihl_reg     <= '0;
            gre_reg     <= 1'b0;
        end else if (in_accept) begin
            pos_reg     <= pos_next;
            type_hi_reg <= type_hi_next;
            vlan_reg    <= vlan_next;
            ihl_reg     <= ihl_next;
            gre_reg     <= gre_next;
        end
    end

endmodule
